@@ rtl/first_fit_heap_allocator_defines.svh @@
// Assertion macros used by the checker file of the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FFHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("first_fit_heap_allocator: assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("first_fit_heap_allocator: assertion failed");

`endif

@@ rtl/ffha_pkg.sv @@
// Package: shared constants, codes and control structs of the heap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

   localparam int HEAP_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int ALLOC_W          = 13;
   localparam int OFFSET_W         = 12;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic {
      RD_START,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_INIT,
      WR_TAKE,
      WR_REST,
      WR_FREE,
      WR_MERGE
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       adv;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cap_size;
      logic       res_load;
      logic       res_grant;
      logic       res_payload;
      logic       post;
   } ffha_cmd_type;

   typedef struct packed {
      logic bad_alloc;
      logic bad_free;
      logic hdr_free;
      logic exact_fit;
      logic split_fit;
      logic split_in_heap;
      logic walk_end;
      logic past_room;
      logic merge_in_heap;
      logic slot_free;
   } ffha_status_type;

endpackage

`default_nettype wire

@@ rtl/ffha_if.sv @@
// Interfaces: request and response channels of the heap allocator.
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if import ffha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [ALLOC_W-1:0]  alloc_bytes;
   logic [OFFSET_W-1:0] free_offset;

   modport source (output valid, output req_type, output alloc_bytes, output free_offset,
                   input ready);
   modport sink (input valid, input req_type, input alloc_bytes, input free_offset,
                 output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                granted;
   logic [OFFSET_W-1:0] payload_offset;

   modport source (output valid, output granted, output payload_offset, input ready);
   modport sink (input valid, input granted, input payload_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/ffha_datapath.sv @@
// Datapath: header memory, walk cursor, size arithmetic and response register.
`timescale 1ns / 1ps
`default_nettype none

module ffha_datapath import ffha_pkg::*; #(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ffha_cmd_type        cmd,
   output ffha_status_type     status,
   input  logic                req_type,
   input  logic [ALLOC_W-1:0]  alloc_bytes,
   input  logic [OFFSET_W-1:0] free_offset,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_granted,
   output logic [OFFSET_W-1:0] rsp_payload_offset
);

   localparam int OFF_W   = $clog2(HEAP_BYTES);
   localparam int SIZE_W  = OFF_W;
   localparam int ENTRY_W = SIZE_W + 1;
   localparam int WIDE_W  = ((OFF_W > ALLOC_W) ? OFF_W : ALLOC_W) + 2;

   localparam logic [WIDE_W-1:0] HEAP_W   = WIDE_W'(HEAP_BYTES);
   localparam logic [WIDE_W-1:0] HDR_W    = WIDE_W'(HEADER_BYTES);
   localparam logic [WIDE_W-1:0] MAX_WANT = WIDE_W'(HEAP_BYTES - HEADER_BYTES);

   // Entry layout: {size, free}
   logic [ENTRY_W-1:0]  mem [HEAP_BYTES];
   logic [ENTRY_W-1:0]  rd_data_ff;

   logic [OFF_W-1:0]    off_ff, off_in;
   logic [SIZE_W-1:0]   want_ff, want_in;
   logic [SIZE_W-1:0]   hsize_ff, hsize_in;
   logic                res_ok_ff, res_ok_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic [SIZE_W-1:0]   rd_size;
   logic                rd_free;
   logic [WIDE_W-1:0]   off_w, want_w, rd_size_w, hsize_w;
   logic [WIDE_W-1:0]   alloc_w, poff_w, next_w, rest_w, room_w, merged_w, merged_sat;
   logic [OFF_W-1:0]    start_off, rd_addr, wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   assign rd_size   = rd_data_ff[ENTRY_W-1:1];
   assign rd_free   = rd_data_ff[0];
   assign off_w     = WIDE_W'(off_ff);
   assign want_w    = WIDE_W'(want_ff);
   assign rd_size_w = WIDE_W'(rd_size);
   assign hsize_w   = WIDE_W'(hsize_ff);
   assign alloc_w   = WIDE_W'(alloc_bytes);
   assign poff_w    = WIDE_W'(free_offset);
   assign next_w    = off_w + HDR_W + rd_size_w;
   assign rest_w    = hsize_w - want_w - HDR_W;
   assign room_w    = HEAP_W - HDR_W - off_w;
   assign merged_w  = hsize_w + rd_size_w + HDR_W;
   assign merged_sat = (merged_w > room_w) ? room_w : merged_w;
   assign start_off = (req_type == REQ_FREE) ? OFF_W'(poff_w - HDR_W) : '0;

   always_comb begin
      status.bad_alloc     = (alloc_w == '0) || (alloc_w > MAX_WANT);
      status.bad_free      = (poff_w < HDR_W) || ((poff_w - HDR_W) >= HEAP_W);
      status.hdr_free      = rd_free;
      status.exact_fit     = (rd_size_w == want_w);
      status.split_fit     = (rd_size_w > (want_w + HDR_W));
      status.split_in_heap = ((off_w + HDR_W + want_w) < HEAP_W);
      status.walk_end      = (next_w >= HEAP_W);
      status.past_room     = (next_w > HEAP_W);
      status.merge_in_heap = ((next_w + HDR_W) <= HEAP_W);
      status.slot_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_START: rd_addr = start_off;
         RD_NEXT:  rd_addr = OFF_W'(next_w);
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_INIT: begin
            wr_addr = '0;
            wr_data = {SIZE_W'(MAX_WANT), 1'b1};
         end
         WR_TAKE: begin
            wr_addr = off_ff;
            wr_data = {want_ff, 1'b0};
         end
         WR_REST: begin
            wr_addr = OFF_W'(off_w + HDR_W + want_w);
            wr_data = {SIZE_W'(rest_w), 1'b1};
         end
         WR_FREE: begin
            wr_addr = off_ff;
            wr_data = {rd_size, 1'b1};
         end
         WR_MERGE: begin
            wr_addr = off_ff;
            wr_data = {SIZE_W'(merged_sat), 1'b1};
         end
         default: begin
            wr_addr = off_ff;
            wr_data = {rd_size, rd_free};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      off_in         = off_ff;
      want_in        = want_ff;
      hsize_in       = hsize_ff;
      res_ok_in      = res_ok_ff;
      res_off_in     = res_off_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_offset_in  = rsp_offset_ff;
      if (cmd.load) begin
         off_in  = start_off;
         want_in = SIZE_W'(alloc_w);
      end else if (cmd.adv) begin
         off_in = OFF_W'(next_w);
      end
      if (cmd.cap_size) begin
         hsize_in = rd_size;
      end
      if (cmd.res_load) begin
         res_ok_in  = cmd.res_grant;
         res_off_in = cmd.res_payload ? OFFSET_W'(off_w + HDR_W) : '0;
      end
      if (cmd.post) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_ok_ff;
         rsp_offset_in  = res_off_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff         <= off_in;
      want_ff        <= want_in;
      hsize_ff       <= hsize_in;
      res_ok_ff      <= res_ok_in;
      res_off_ff     <= res_off_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_offset_ff  <= rsp_offset_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_payload_offset = rsp_offset_ff;

endmodule

`default_nettype wire

@@ rtl/ffha_ctrl.sv @@
// Controller: sequences the header walk, split, free and merge steps.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl import ffha_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_type,
   output logic            req_ready,
   input  ffha_status_type status,
   output ffha_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_EVAL,
      ST_A_SPLIT,
      ST_F_EVAL,
      ST_F_MERGE,
      ST_POST
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_INIT;
            state_in   = ST_IDLE;
            ready_in   = 1'b1;
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               ready_in = 1'b0;
               if ((req_type == REQ_ALLOC) ? status.bad_alloc : status.bad_free) begin
                  cmd.res_load = 1'b1;
                  state_in     = ST_POST;
               end else begin
                  cmd.load   = 1'b1;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_START;
                  state_in   = (req_type == REQ_ALLOC) ? ST_A_EVAL : ST_F_EVAL;
               end
            end
         end
         ST_A_EVAL: begin
            priority if (status.hdr_free && (status.exact_fit || status.split_fit)) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_sel      = WR_TAKE;
               cmd.cap_size    = 1'b1;
               cmd.res_load    = 1'b1;
               cmd.res_grant   = 1'b1;
               cmd.res_payload = 1'b1;
               state_in = (!status.exact_fit && status.split_in_heap) ? ST_A_SPLIT : ST_POST;
            end else if (status.walk_end) begin
               cmd.res_load = 1'b1;
               state_in     = ST_POST;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               cmd.adv    = 1'b1;
            end
         end
         ST_A_SPLIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REST;
            state_in   = ST_POST;
         end
         ST_F_EVAL: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_FREE;
            cmd.cap_size  = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_grant = 1'b1;
            if (!status.past_room && status.merge_in_heap) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_F_MERGE;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_F_MERGE: begin
            cmd.wr_en  = status.hdr_free;
            cmd.wr_sel = WR_MERGE;
            state_in   = ST_POST;
         end
         ST_POST: begin
            if (status.slot_free) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// Top level: first-fit heap allocator over an implicit header list.
`timescale 1ns / 1ps
`default_nettype none

// The heap of HEAP_BYTES bytes is a chain of blocks, each opened by a header
// of HEADER_BYTES bytes that holds the payload size and a free mark; headers
// live in a single-port-write, single-port-read memory indexed by byte offset.
// One request is in flight at a time. An allocate is transferred, then walks
// the headers from offset 0 with one memory read per header visited, writes a
// split header when the block is split, and posts the response. A free reads
// its header, marks it free and reads the next header, merges if that one is
// free, and posts. Bad sizes and bad offsets go straight to the post. After
// reset the block writes the initial whole-heap free header before ready
// rises. A finished response waits in an output register, so the next request
// transfers while it is still pending; its own response holds until the slot
// drains.
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan
);

   ffha_cmd_type    cmd;
   ffha_status_type status;

   // Sequence the walk; issue memory, cursor and response commands.
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the header memory, do the size math, drive the response register.
   ffha_datapath #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_chan.req_type),
      .alloc_bytes        (req_chan.alloc_bytes),
      .free_offset        (req_chan.free_offset),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_granted        (rsp_chan.granted),
      .rsp_payload_offset (rsp_chan.payload_offset)
   );

endmodule

`default_nettype wire

@@ rtl/ffha_checker.sv @@
// Checker: port-level assertions for the heap allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker import ffha_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_granted,
   input logic [OFFSET_W-1:0] rsp_payload_offset
);

   `FFHA_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `FFHA_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   `FFHA_ASSERT_IMPL(a_deny_zero_offset, clock, reset, rsp_valid && !rsp_granted, rsp_payload_offset == '0)
   `FFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FFHA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_granted) && $stable(rsp_payload_offset))

endmodule

bind first_fit_heap_allocator ffha_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_granted        (rsp_chan.granted),
   .rsp_payload_offset (rsp_chan.payload_offset)
);

`default_nettype wire
